// ----- sv/html_char_reference_decoder_macros.svh -----
// Assertion macros shared by the HTML character reference decoder RTL.
`ifndef HTML_CHAR_REFERENCE_DECODER_MACROS_SVH
`define HTML_CHAR_REFERENCE_DECODER_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked on every rising edge outside reset.
`define HCRD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define HCRD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define HCRD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define HCRD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- sv/hcrd_pkg.sv -----
// Types, constants and the entity table of the HTML character reference decoder.
`default_nettype none

package hcrd_pkg;

    localparam int NUM_ENT = 19;

    localparam logic [20:0] MAX_CODE    = 21'h10FFFF;
    localparam logic [20:0] LIM_1BYTE   = 21'h00007F;
    localparam logic [20:0] LIM_2BYTE   = 21'h0007FF;
    localparam logic [20:0] LIM_3BYTE   = 21'h00FFFF;
    localparam logic [7:0]  UTF8_LEAD2  = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3  = 8'hE0;
    localparam logic [7:0]  UTF8_LEAD4  = 8'hF0;
    localparam logic [7:0]  UTF8_CONT   = 8'h80;
    localparam logic [2:0]  ROOM_RESET  = 3'd4;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_NAMED = 2'd1,
        KIND_DEC   = 2'd2,
        KIND_HEX   = 2'd3
    } t_kind;

    // One pending output burst: byte 0 goes out first.
    typedef struct packed {
        logic [3:0][7:0] data;
        logic [1:0]      last_idx;
        logic            status;
    } t_burst;

    localparam logic [7:0] Z = 8'h00;

    // Entity names, padded to eight characters so a 3-bit position indexes them.
    localparam logic [7:0] ENT_NAME [NUM_ENT][8] = '{
        '{"a", "m", "p", Z,   Z,   Z,   Z, Z},
        '{"l", "t", Z,   Z,   Z,   Z,   Z, Z},
        '{"g", "t", Z,   Z,   Z,   Z,   Z, Z},
        '{"q", "u", "o", "t", Z,   Z,   Z, Z},
        '{"a", "p", "o", "s", Z,   Z,   Z, Z},
        '{"n", "b", "s", "p", Z,   Z,   Z, Z},
        '{"c", "o", "p", "y", Z,   Z,   Z, Z},
        '{"r", "e", "g", Z,   Z,   Z,   Z, Z},
        '{"t", "r", "a", "d", "e", Z,   Z, Z},
        '{"m", "d", "a", "s", "h", Z,   Z, Z},
        '{"n", "d", "a", "s", "h", Z,   Z, Z},
        '{"h", "e", "l", "l", "i", "p", Z, Z},
        '{"l", "s", "q", "u", "o", Z,   Z, Z},
        '{"r", "s", "q", "u", "o", Z,   Z, Z},
        '{"l", "d", "q", "u", "o", Z,   Z, Z},
        '{"r", "d", "q", "u", "o", Z,   Z, Z},
        '{"m", "i", "d", "d", "o", "t", Z, Z},
        '{"b", "u", "l", "l", Z,   Z,   Z, Z},
        '{"d", "e", "g", Z,   Z,   Z,   Z, Z}
    };

    localparam logic [2:0] ENT_NLEN [NUM_ENT] = '{
        3'd3, 3'd2, 3'd2, 3'd4, 3'd4, 3'd4, 3'd4, 3'd3, 3'd5, 3'd5,
        3'd5, 3'd6, 3'd5, 3'd5, 3'd5, 3'd5, 3'd6, 3'd4, 3'd3
    };

    localparam logic [2:0] ENT_VLEN [NUM_ENT] = '{
        3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3,
        3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd2, 3'd3, 3'd2
    };

    // UTF-8 bytes, first byte in the lowest lane.
    localparam logic [3:0][7:0] ENT_VAL [NUM_ENT] = '{
        {8'h00, 8'h00, 8'h00, 8'h26},
        {8'h00, 8'h00, 8'h00, 8'h3C},
        {8'h00, 8'h00, 8'h00, 8'h3E},
        {8'h00, 8'h00, 8'h00, 8'h22},
        {8'h00, 8'h00, 8'h00, 8'h27},
        {8'h00, 8'h00, 8'hA0, 8'hC2},
        {8'h00, 8'h00, 8'hA9, 8'hC2},
        {8'h00, 8'h00, 8'hAE, 8'hC2},
        {8'h00, 8'hA2, 8'h84, 8'hE2},
        {8'h00, 8'h94, 8'h80, 8'hE2},
        {8'h00, 8'h93, 8'h80, 8'hE2},
        {8'h00, 8'hA6, 8'h80, 8'hE2},
        {8'h00, 8'h98, 8'h80, 8'hE2},
        {8'h00, 8'h99, 8'h80, 8'hE2},
        {8'h00, 8'h9C, 8'h80, 8'hE2},
        {8'h00, 8'h9D, 8'h80, 8'hE2},
        {8'h00, 8'h00, 8'hB7, 8'hC2},
        {8'h00, 8'hA2, 8'h80, 8'hE2},
        {8'h00, 8'h00, 8'hB0, 8'hC2}
    };

endpackage

`default_nettype wire

// ----- sv/hcrd_step.sv -----
// Input register, per-character state update and burst generation.
`default_nettype none

module hcrd_step
    import hcrd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_char,
    input  wire logic       i_last,
    input  wire logic [2:0] i_room,
    input  wire logic       i_burst_ready,
    output logic            o_load,
    output t_burst          o_burst
);

    logic                 r_in_valid;
    logic [7:0]           r_in_char;
    logic                 r_in_last;

    t_kind                r_kind,  n_kind;
    logic [2:0]           r_pos,   n_pos;
    logic [NUM_ENT-1:0]   r_match, n_match;
    logic [20:0]          r_code,  n_code;
    logic                 r_bad,   n_bad;
    logic                 r_seen,  n_seen;

    logic                 w_advance;

    assign w_advance = r_in_valid && (!r_in_last || i_burst_ready);
    assign o_ready   = !r_in_valid || w_advance;
    assign o_load    = w_advance && r_in_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready) begin
            r_in_char <= i_char;
            r_in_last <= i_last;
        end
    end

    // Next state for the character held in the input register.
    always_comb begin
        logic       is_dec;
        logic       is_hexl;
        logic       is_hexu;
        logic       dig_ok;
        logic [3:0] d;
        logic [24:0] v;

        n_kind = r_kind;
        n_code = r_code;
        n_bad  = r_bad;
        n_seen = r_seen;
        n_pos  = (r_pos == 3'd7) ? r_pos : r_pos + 3'd1;

        for (int i = 0; i < NUM_ENT; i++) begin
            n_match[i] = r_match[i] && (r_pos < ENT_NLEN[i])
                         && (ENT_NAME[i][r_pos] == r_in_char);
        end

        is_dec  = (r_in_char >= "0") && (r_in_char <= "9");
        is_hexl = (r_in_char >= "a") && (r_in_char <= "f");
        is_hexu = (r_in_char >= "A") && (r_in_char <= "F");
        if (is_dec) begin
            d = 4'(r_in_char - "0");
        end else if (is_hexl) begin
            d = 4'(r_in_char - "a" + 8'd10);
        end else begin
            d = 4'(r_in_char - "A" + 8'd10);
        end
        dig_ok = is_dec || ((r_kind == KIND_HEX) && (is_hexl || is_hexu));

        if (r_kind == KIND_HEX) begin
            v = {r_code, 4'b0000} + {21'b0, d};
        end else begin
            v = {1'b0, r_code, 3'b000} + {3'b000, r_code, 1'b0} + {21'b0, d};
        end

        if (r_pos == 3'd0) begin
            n_kind = (r_in_char == "#") ? KIND_DEC : KIND_NAMED;
        end else if (r_kind == KIND_DEC || r_kind == KIND_HEX) begin
            if (r_pos == 3'd1 && r_kind == KIND_DEC
                && (r_in_char == "x" || r_in_char == "X")) begin
                n_kind = KIND_HEX;
            end else if (!dig_ok) begin
                n_bad = 1'b1;
            end else if (!r_bad) begin
                n_seen = 1'b1;
                if (v > {4'b0000, MAX_CODE}) begin
                    n_bad = 1'b1;
                end else begin
                    n_code = v[20:0];
                end
            end
        end
    end

    // Result burst for a final character, built from the updated state.
    always_comb begin
        logic [2:0]      len;
        logic [3:0][7:0] bytes;
        logic            fail;
        logic [NUM_ENT-1:0] hit;

        len   = 3'd1;
        bytes = '0;
        fail  = 1'b1;
        hit   = '0;

        if (n_kind == KIND_DEC || n_kind == KIND_HEX) begin
            if (n_code <= LIM_1BYTE) begin
                len      = 3'd1;
                bytes[0] = n_code[7:0];
            end else if (n_code <= LIM_2BYTE) begin
                len      = 3'd2;
                bytes[0] = UTF8_LEAD2 | {3'b000, n_code[10:6]};
                bytes[1] = UTF8_CONT | {2'b00, n_code[5:0]};
            end else if (n_code <= LIM_3BYTE) begin
                len      = 3'd3;
                bytes[0] = UTF8_LEAD3 | {4'b0000, n_code[15:12]};
                bytes[1] = UTF8_CONT | {2'b00, n_code[11:6]};
                bytes[2] = UTF8_CONT | {2'b00, n_code[5:0]};
            end else begin
                len      = 3'd4;
                bytes[0] = UTF8_LEAD4 | {5'b00000, n_code[20:18]};
                bytes[1] = UTF8_CONT | {2'b00, n_code[17:12]};
                bytes[2] = UTF8_CONT | {2'b00, n_code[11:6]};
                bytes[3] = UTF8_CONT | {2'b00, n_code[5:0]};
            end
            fail = n_bad || !n_seen;
        end else begin
            // Entity names are distinct, so at most one entry can hit.
            len = 3'd0;
            for (int i = 0; i < NUM_ENT; i++) begin
                hit[i] = n_match[i]
                         && ({1'b0, ENT_NLEN[i]} == ({1'b0, r_pos} + 4'd1));
                if (hit[i]) begin
                    len   = len | ENT_VLEN[i];
                    bytes = bytes | ENT_VAL[i];
                end
            end
            if (hit == '0) begin
                len = 3'd1;
            end
            fail = (hit == '0);
        end

        if (fail || len > i_room) begin
            o_burst.data     = '0;
            o_burst.last_idx = 2'd0;
            o_burst.status   = 1'b1;
        end else begin
            o_burst.data     = bytes;
            o_burst.last_idx = 2'(len - 3'd1);
            o_burst.status   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_advance && r_in_last)) begin
            r_kind  <= KIND_NONE;
            r_pos   <= 3'd0;
            r_match <= '1;
            r_code  <= '0;
            r_bad   <= 1'b0;
            r_seen  <= 1'b0;
        end else if (w_advance) begin
            r_kind  <= n_kind;
            r_pos   <= n_pos;
            r_match <= n_match;
            r_code  <= n_code;
            r_bad   <= n_bad;
            r_seen  <= n_seen;
        end
    end

endmodule

`default_nettype wire

// ----- sv/hcrd_burst.sv -----
// Result register that sends one burst out a byte per transaction.
`default_nettype none

module hcrd_burst
    import hcrd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_load,
    input  wire t_burst     i_burst,
    output logic            o_ready,
    output logic            o_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_byte,
    output logic            o_status,
    output logic            o_last
);

    logic       r_valid;
    t_burst     r_burst;
    logic [1:0] r_idx;
    logic       w_take;

    assign o_valid  = r_valid;
    assign o_byte   = r_burst.data[r_idx];
    assign o_status = r_burst.status;
    assign o_last   = (r_idx == r_burst.last_idx);
    assign w_take   = r_valid && i_out_ready;
    // Free, or the final byte leaves in this cycle.
    assign o_ready  = !r_valid || (w_take && o_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= 2'd0;
        end else if (w_take) begin
            if (o_last) begin
                r_valid <= 1'b0;
                r_idx   <= 2'd0;
            end else begin
                r_idx   <= r_idx + 2'd1;
            end
        end
        if (i_load) begin
            r_burst <= i_burst;
        end
    end

endmodule

`default_nettype wire

// ----- sv/html_char_reference_decoder.sv -----
// Top level of the HTML character reference decoder.
//
// Usage: the characters of one reference name (no ampersand, no semicolon)
// arrive on the s_axis channel, one byte per transaction, with tlast on the
// final character. Numeric names start with '#', hex ones continue with 'x'.
// Non-final characters produce nothing. The final character produces a burst
// on m_axis: one to four UTF-8 bytes with tuser low and tlast on the last
// byte, or a single byte of zero with tuser and tlast high on rejection.
// The final character passes through the input register and then the result
// register before the first output byte. One character is taken per cycle
// unless a final character in the input register waits for the result
// register, busy until its last byte leaves; non-final characters flow on.
// When m_axis_tready is low, the pending byte holds and the input stalls
// only once the input register holds a final character.
// The cfg channel sets the byte limit per reference (reset 4); it is always
// ready. The user must write it only while the block is idle (unchecked).
// Reset clears the name state, the pending burst and restores the limit.
`default_nettype none

`include "html_char_reference_decoder_macros.svh"

module html_char_reference_decoder
    import hcrd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] name_char
    input  wire logic       s_axis_tlast,
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
    output logic            m_axis_tuser,   // [0] status
    output logic            m_axis_tlast,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [2:0] i_cfg_data
);

    logic [2:0] r_out_room;
    logic       w_load;
    logic       w_burst_ready;
    t_burst     w_burst;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_room <= ROOM_RESET;
        end else if (i_cfg_valid) begin
            r_out_room <= i_cfg_data;
        end
    end

    hcrd_step u_step (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_char        (s_axis_tdata),
        .i_last        (s_axis_tlast),
        .i_room        (r_out_room),
        .i_burst_ready (w_burst_ready),
        .o_load        (w_load),
        .o_burst       (w_burst)
    );

    hcrd_burst u_burst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_load),
        .i_burst     (w_burst),
        .o_ready     (w_burst_ready),
        .o_valid     (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_byte      (m_axis_tdata),
        .o_status    (m_axis_tuser),
        .o_last      (m_axis_tlast)
    );

    // A rejection is a single zero byte that closes the reference.
    `HCRD_ASSERT_IMP(a_reject_single, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tlast && (m_axis_tdata == 8'h00))
    // A new burst is only loaded when the result register can take it.
    `HCRD_ASSERT_IMP(a_load_free, i_clk, i_rst_n, w_load, w_burst_ready)
    // After the final byte leaves and nothing new is loaded, the output goes idle.
    `HCRD_ASSERT_NXT(a_drain_idle, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready && m_axis_tlast && !w_load, !m_axis_tvalid)

endmodule

`default_nettype wire
